### rtl/alpha_error_diffusion_dither_top_macros.svh
// Assertion macros used by the dither back end (aedd_back).
`ifndef ALPHA_ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH
`define ALPHA_ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AEDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AEDD_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AEDD_ASSERT(lbl, prop, msg)
`define AEDD_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

### rtl/aedd_pkg.sv
// Package: widths, item and write-entry types, saturation helper for the dither.
`timescale 1ns / 1ps
`default_nettype none

package aedd_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int LW_W         = 11;
  localparam int ALPHA_W      = 8;
  localparam int ERR_W        = 9;
  localparam int CARRY_W      = 10;
  localparam int ITEM_Q_DEPTH = 2;
  localparam int Q_PTR_W      = $clog2(ITEM_Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(ITEM_Q_DEPTH + 1);
  localparam int WQ_DEPTH     = 4;
  localparam int WQ_IDX_W     = $clog2(WQ_DEPTH);
  localparam int WQ_CNT_W     = $clog2(WQ_DEPTH + 1);
  localparam int NPUSH        = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ON  = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_OFF = 8'h00;
  localparam logic signed [11:0] FULL_SCALE = 12'sd255;
  localparam logic signed [11:0] THRESHOLD  = 12'sh080;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               sof;
    logic [COL_W-1:0]   col;
    logic               last;
    logic               first_row;
    logic               buf_sel;
  } item_t;

  typedef struct packed {
    logic                    buf_sel;
    logic [COL_W-1:0]        addr;
    logic signed [ERR_W-1:0] data;
  } wr_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [13:0] v);
    logic signed [ERR_W-1:0] r;
    if (v < -14'sd256) begin
      r = -9'sd256;
    end else if (v > 14'sd255) begin
      r = 9'sd255;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/alpha_error_diffusion_dither_top.sv
// Top level: alpha error-diffusion dither with line width register.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------
//   in      | in_valid / in_ready    | alpha_in[7:0], start_of_image
//   out     | out_valid / out_ready  | alpha_out[7:0]
//   cfg     | cfg_valid / cfg_ready  | cfg_data[10:0] -> line_width
//
// One item per clock while the output is not stalled, set by the back-end error loop.
// Results pass the item queue, then the output register; row writes drain one per clock.
// rst is synchronous; no store clearing is needed, so items are taken right after reset.
// A stalled output holds the back end; the item queue keeps taking items until it fills.
`timescale 1ns / 1ps
`default_nettype none

module alpha_error_diffusion_dither_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [aedd_pkg::ALPHA_W-1:0] alpha_in,
  input  logic                         start_of_image,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [aedd_pkg::ALPHA_W-1:0] alpha_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aedd_pkg::LW_W-1:0]    cfg_data
);

  logic [aedd_pkg::LW_W-1:0] line_width;
  logic                      f_valid;
  logic                      f_ready;
  aedd_pkg::item_t           f_item;
  logic                      b_valid;
  logic                      b_ready;
  aedd_pkg::item_t           b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= aedd_pkg::LW_W'(aedd_pkg::MAX_WIDTH);
    end else if (cfg_valid) begin
      line_width <= cfg_data;
    end
  end

  aedd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .alpha_in       (alpha_in),
    .start_of_image (start_of_image),
    .line_width     (line_width),
    .push_valid     (f_valid),
    .push_ready     (f_ready),
    .push_item      (f_item)
  );

  aedd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  aedd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .alpha_out (alpha_out)
  );

endmodule

`default_nettype wire

### rtl/aedd_front.sv
// Front end: accept pixels, track column, row and buffer, tag each item.
`timescale 1ns / 1ps
`default_nettype none

module aedd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [aedd_pkg::ALPHA_W-1:0] alpha_in,
  input  logic                         start_of_image,
  input  logic [aedd_pkg::LW_W-1:0]    line_width,
  output logic                         push_valid,
  input  logic                         push_ready,
  output aedd_pkg::item_t              push_item
);

  logic [aedd_pkg::COL_W-1:0] column;
  logic                       first_row;
  logic                       buffer_select;
  logic [aedd_pkg::COL_W-1:0] x;
  logic                       fr;
  logic                       bs;
  logic [aedd_pkg::LW_W-1:0]  w_eff;
  logic                       last;

  always_comb begin
    x  = start_of_image ? '0 : column;
    fr = start_of_image ? 1'b1 : first_row;
    bs = start_of_image ? 1'b0 : buffer_select;
    if (line_width == '0) begin
      w_eff = aedd_pkg::LW_W'(1);
    end else if (line_width > aedd_pkg::LW_W'(aedd_pkg::MAX_WIDTH)) begin
      w_eff = aedd_pkg::LW_W'(aedd_pkg::MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    last = ({1'b0, x} + aedd_pkg::LW_W'(1)) >= w_eff;
    push_item.alpha     = alpha_in;
    push_item.sof       = start_of_image;
    push_item.col       = x;
    push_item.last      = last;
    push_item.first_row = fr;
    push_item.buf_sel   = bs;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      first_row     <= 1'b1;
      buffer_select <= 1'b0;
    end else if (in_valid && push_ready) begin
      if (last) begin
        column        <= '0;
        first_row     <= 1'b0;
        buffer_select <= ~bs;
      end else begin
        column        <= x + aedd_pkg::COL_W'(1);
        first_row     <= fr;
        buffer_select <= bs;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/aedd_fifo.sv
// Short item queue between the front end and the error back end.
`timescale 1ns / 1ps
`default_nettype none

module aedd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  aedd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output aedd_pkg::item_t pop_item
);

  aedd_pkg::item_t                slots [aedd_pkg::ITEM_Q_DEPTH];
  logic [aedd_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [aedd_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [aedd_pkg::Q_CNT_W-1:0]   count;
  logic                           push;
  logic                           pop;

  assign push_ready = count != aedd_pkg::Q_CNT_W'(aedd_pkg::ITEM_Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + aedd_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + aedd_pkg::Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + aedd_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - aedd_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/aedd_back.sv
// Back end: error recurrence, ping-pong row stores, write queue, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_error_diffusion_dither_top_macros.svh"

module aedd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  aedd_pkg::item_t              q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [aedd_pkg::ALPHA_W-1:0] alpha_out
);

  logic signed [aedd_pkg::ERR_W-1:0] row_error_a [aedd_pkg::MAX_WIDTH];
  logic signed [aedd_pkg::ERR_W-1:0] row_error_b [aedd_pkg::MAX_WIDTH];
  logic signed [aedd_pkg::ERR_W-1:0] rd_a;
  logic signed [aedd_pkg::ERR_W-1:0] rd_b;
  logic                              rd_from_a;
  logic                              fwd_hit;
  logic signed [aedd_pkg::ERR_W-1:0] fwd_val;
  logic                              use_rd;

  logic signed [aedd_pkg::CARRY_W-1:0] cpart;
  logic signed [aedd_pkg::ERR_W-1:0]   pn;
  logic signed [aedd_pkg::ERR_W-1:0]   pf;

  aedd_pkg::wr_t                  wq [aedd_pkg::WQ_DEPTH];
  aedd_pkg::wr_t                  wq_next [aedd_pkg::WQ_DEPTH];
  aedd_pkg::wr_t                  wq_sh [aedd_pkg::WQ_DEPTH];
  logic [aedd_pkg::WQ_CNT_W-1:0]  wq_cnt;
  logic [aedd_pkg::WQ_CNT_W-1:0]  wq_cnt_next;
  logic [aedd_pkg::WQ_CNT_W-1:0]  base;
  logic [aedd_pkg::WQ_CNT_W-1:0]  k;
  logic                           pop;

  aedd_pkg::wr_t                  p_ent [aedd_pkg::NPUSH];
  logic                           p_ok [aedd_pkg::NPUSH];
  aedd_pkg::wr_t                  packed_ent [aedd_pkg::NPUSH];
  logic [aedd_pkg::WQ_CNT_W-1:0]  npush;

  logic                                proc;
  logic signed [aedd_pkg::ERR_W-1:0]   rd_val;
  logic signed [aedd_pkg::CARRY_W-1:0] rd_add;
  logic signed [aedd_pkg::CARRY_W-1:0] carry_now;
  logic signed [aedd_pkg::ERR_W-1:0]   pn_eff;
  logic signed [aedd_pkg::ERR_W-1:0]   pf_eff;
  logic signed [11:0]                  val;
  logic signed [11:0]                  e12;
  logic                                dark;
  logic signed [12:0]                  e13;
  logic signed [12:0]                  e3;
  logic signed [12:0]                  e5;
  logic signed [12:0]                  e7;
  logic signed [12:0]                  f1;
  logic signed [12:0]                  f3;
  logic signed [12:0]                  f5;
  logic signed [12:0]                  f7;
  logic signed [aedd_pkg::ERR_W-1:0]   wval;
  logic signed [aedd_pkg::ERR_W-1:0]   pf_next;
  logic signed [aedd_pkg::ERR_W-1:0]   pn_next;
  logic                                rbuf;
  logic                                hit_c;
  logic signed [aedd_pkg::ERR_W-1:0]   hit_val_c;

  assign proc    = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;
  assign pop     = wq_cnt != '0;

  always_comb begin
    rd_val    = fwd_hit ? fwd_val : (rd_from_a ? rd_a : rd_b);
    rd_add    = use_rd ? {rd_val[aedd_pkg::ERR_W-1], rd_val} : '0;
    carry_now = q_item.sof ? '0 : cpart + rd_add;
    pn_eff    = q_item.sof ? '0 : pn;
    pf_eff    = q_item.sof ? '0 : pf;
    val  = aedd_pkg::FULL_SCALE - $signed({4'b0000, q_item.alpha})
         + {{2{carry_now[aedd_pkg::CARRY_W-1]}}, carry_now};
    dark = val < aedd_pkg::THRESHOLD;
    e12  = dark ? val : val - aedd_pkg::FULL_SCALE;
    e13  = {e12[11], e12};
    e3   = (e13 <<< 1) + e13;
    e5   = (e13 <<< 2) + e13;
    e7   = (e13 <<< 3) - e13;
    f1   = e13 >>> 4;
    f3   = e3 >>> 4;
    f5   = e5 >>> 4;
    f7   = e7 >>> 4;
    wval    = aedd_pkg::sat_err({{5{pf_eff[aedd_pkg::ERR_W-1]}}, pf_eff} + {f3[12], f3});
    pf_next = aedd_pkg::sat_err({{5{pn_eff[aedd_pkg::ERR_W-1]}}, pn_eff} + {f5[12], f5});
    pn_next = aedd_pkg::sat_err({f1[12], f1});
  end

  // forward pending writes to the read of the other buffer
  always_comb begin
    rbuf      = ~q_item.buf_sel;
    hit_c     = 1'b0;
    hit_val_c = '0;
    for (int i = 0; i < aedd_pkg::WQ_DEPTH; i++) begin
      if (aedd_pkg::WQ_CNT_W'(i) < wq_cnt && wq[i].buf_sel == rbuf &&
          wq[i].addr == q_item.col) begin
        hit_c     = 1'b1;
        hit_val_c = wq[i].data;
      end
    end
  end

  always_comb begin
    p_ent[0].buf_sel = q_item.buf_sel;
    p_ent[0].addr    = q_item.col - aedd_pkg::COL_W'(2);
    p_ent[0].data    = wval;
    p_ok[0]          = proc && (q_item.col >= aedd_pkg::COL_W'(2));
    p_ent[1].buf_sel = q_item.buf_sel;
    p_ent[1].addr    = q_item.col - aedd_pkg::COL_W'(1);
    p_ent[1].data    = pf_next;
    p_ok[1]          = proc && q_item.last && (q_item.col != '0);
    p_ent[2].buf_sel = q_item.buf_sel;
    p_ent[2].addr    = q_item.col;
    p_ent[2].data    = pn_next;
    p_ok[2]          = proc && q_item.last;
    npush = '0;
    for (int j = 0; j < aedd_pkg::NPUSH; j++) begin
      packed_ent[j] = p_ent[0];
    end
    for (int j = 0; j < aedd_pkg::NPUSH; j++) begin
      if (p_ok[j]) begin
        packed_ent[npush[1:0]] = p_ent[j];
        npush = npush + aedd_pkg::WQ_CNT_W'(1);
      end
    end
  end

  always_comb begin
    base = wq_cnt - aedd_pkg::WQ_CNT_W'(pop);
    for (int i = 0; i < aedd_pkg::WQ_DEPTH; i++) begin
      if (pop && i < aedd_pkg::WQ_DEPTH - 1) begin
        wq_sh[i] = wq[i+1];
      end else begin
        wq_sh[i] = wq[i];
      end
    end
    k = '0;
    for (int i = 0; i < aedd_pkg::WQ_DEPTH; i++) begin
      k          = aedd_pkg::WQ_CNT_W'(i) - base;
      wq_next[i] = wq_sh[i];
      if (aedd_pkg::WQ_CNT_W'(i) >= base && k < npush) begin
        wq_next[i] = packed_ent[k[1:0]];
      end
    end
    wq_cnt_next = base + npush;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < aedd_pkg::WQ_DEPTH; i++) begin
      wq[i] <= wq_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !wq[0].buf_sel) begin
      row_error_a[wq[0].addr] <= wq[0].data;
    end
    if (proc) begin
      rd_a <= row_error_a[q_item.col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wq[0].buf_sel) begin
      row_error_b[wq[0].addr] <= wq[0].data;
    end
    if (proc) begin
      rd_b <= row_error_b[q_item.col];
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rd_from_a <= q_item.buf_sel;
      fwd_hit   <= hit_c;
      fwd_val   <= hit_val_c;
      alpha_out <= dark ? aedd_pkg::ALPHA_ON : aedd_pkg::ALPHA_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wq_cnt    <= '0;
      out_valid <= 1'b0;
      cpart     <= '0;
      pn        <= '0;
      pf        <= '0;
      use_rd    <= 1'b0;
    end else begin
      wq_cnt    <= wq_cnt_next;
      out_valid <= proc || (out_valid && !out_ready);
      if (proc) begin
        if (q_item.last) begin
          cpart  <= '0;
          pn     <= '0;
          pf     <= '0;
          use_rd <= 1'b0;
        end else begin
          cpart  <= f7[aedd_pkg::CARRY_W-1:0];
          pn     <= pn_next;
          pf     <= pf_next;
          use_rd <= !q_item.first_row;
        end
      end
    end
  end

  `AEDD_ASSERT(a_wq_bound, wq_cnt <= aedd_pkg::WQ_CNT_W'(aedd_pkg::WQ_DEPTH), "write queue overflow")
  `AEDD_ASSERT(a_push_room, proc |-> (4'(wq_cnt) + 4'(npush) <= 4'(aedd_pkg::WQ_DEPTH) + 4'(pop)), "no room for row writes")
  `AEDD_ASSERT(a_out_code, out_valid |-> (alpha_out == aedd_pkg::ALPHA_ON || alpha_out == aedd_pkg::ALPHA_OFF), "bad output code")
  `AEDD_ASSERT(a_first_row_mask, proc && q_item.first_row |=> !use_rd, "first row read not masked")
  `AEDD_ASSERT(a_row_end_clear, proc && q_item.last |=> cpart == '0 && pn == '0 && pf == '0, "row end left error")
  `AEDD_ASSERT_NORST(a_rst_idle, rst |=> !out_valid && wq_cnt == '0, "reset left work pending")

endmodule

`default_nettype wire
